### hdl/vlc_pkg.sv
// Shared types and constants for the letter cipher block.
// No dependencies; imported by vlc_fe, vlc_be and the top level.
`default_nettype none
package vlc_pkg;

  localparam int unsigned LETTER_W  = 16;
  localparam int unsigned OFF_W     = 5;
  localparam int unsigned KLEN_W    = 7;
  localparam int unsigned KIDX_W    = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LETTER_W-1:0] LAT_BASE = 16'd65;
  localparam logic [LETTER_W-1:0] LAT_LAST = 16'd90;
  localparam logic [LETTER_W-1:0] RUS_BASE = 16'd1040;
  localparam logic [LETTER_W-1:0] RUS_LAST = 16'd1071;
  localparam logic [OFF_W:0]      LAT_SIZE = 6'd26;
  localparam logic [OFF_W:0]      RUS_SIZE = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_LANGUAGE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ENC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [LETTER_W-1:0] letter;
    logic                in_alpha;
    logic                lang;
    logic [OFF_W-1:0]    key;
  } item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter_out;
    logic                bad_letter;
  } res_t;

endpackage
`default_nettype wire

### hdl/vlc_fifo.sv
// Small synchronous queue of Depth entries of type T.
// Depends on nothing; used between the front and back parts and at the output.
`default_nettype none
module vlc_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      full_o,
  input  wire T     data_i,
  input  wire logic pop_i,
  output logic      empty_o,
  output T          data_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  T                mem_q [Depth];
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### hdl/vlc_fe.sv
// Front part: configuration registers, key position, key store and item classification.
// Depends on vlc_pkg.
`default_nettype none
module vlc_fe #(
  parameter int unsigned KEY_MAX = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [vlc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [vlc_pkg::KLEN_W-1:0]       cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       mode_i,
  input  wire logic [vlc_pkg::LETTER_W-1:0]     letter_i,
  input  wire logic [vlc_pkg::KIDX_W-1:0]       key_index_i,
  input  wire logic                             restart_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output vlc_pkg::item_t                        out_item_o
);
  import vlc_pkg::*;

  localparam int unsigned PosW = $clog2(KEY_MAX);
  localparam int unsigned CntW = ($clog2(KEY_MAX + 1) > KLEN_W) ? $clog2(KEY_MAX + 1) : KLEN_W;

  logic                lang_q;
  logic [KLEN_W-1:0]   klen_q;
  logic [PosW-1:0]     pos_q, pos_d, pos_start;
  logic [CntW-1:0]     klen_ext, eff_len, pos_inc;
  logic                s_v_q, s_v_d;
  item_t               item_q;
  logic [OFF_W-1:0]    key_q;
  logic [OFF_W-1:0]    key_mem [KEY_MAX];
  logic [OFF_W-1:0]    load_off;
  logic [LETTER_W-1:0] base, last;
  logic                in_alpha, text_op, accept, kidx_ok;
  op_e                 op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lang_q <= 1'b0;
      klen_q <= KLEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LANGUAGE:   lang_q <= cfg_data_i[0];
        CFG_KEY_LENGTH: klen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign op         = op_e'(mode_i);
  assign in_ready_o = !s_v_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign base       = lang_q ? RUS_BASE : LAT_BASE;
  assign last       = lang_q ? RUS_LAST : LAT_LAST;
  assign in_alpha   = (letter_i >= base) && (letter_i <= last);
  assign text_op    = (op == OP_ENC) || (op == OP_DEC);
  assign kidx_ok    = CntW'(key_index_i) < CntW'(KEY_MAX);
  assign load_off   = in_alpha ? OFF_W'(letter_i - base) : '0;

  assign klen_ext  = CntW'(klen_q);
  assign eff_len   = (klen_ext == '0) ? CntW'(1) :
                     (klen_ext > CntW'(KEY_MAX)) ? CntW'(KEY_MAX) : klen_ext;
  assign pos_start = restart_i ? '0 : pos_q;
  assign pos_inc   = CntW'(pos_start) + 1'b1;

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (text_op) begin
        pos_d = (pos_inc >= eff_len) ? '0 : PosW'(pos_inc);
      end else begin
        pos_d = pos_start;
      end
    end
  end

  always_comb begin
    s_v_d = s_v_q;
    if (accept) begin
      s_v_d = 1'b1;
    end else if (out_ready_i) begin
      s_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      s_v_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      s_v_q <= s_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op       <= op;
      item_q.letter   <= letter_i;
      item_q.in_alpha <= in_alpha;
      item_q.lang     <= lang_q;
      item_q.key      <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (op == OP_LOAD) && kidx_ok) begin
      key_mem[PosW'(key_index_i)] <= load_off;
    end
    if (accept) begin
      key_q <= key_mem[pos_start];
    end
  end

  assign out_valid_o = s_v_q;

  always_comb begin
    out_item_o     = item_q;
    out_item_o.key = key_q;
  end

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && text_op && !restart_i |=>
      (pos_q == '0) || (pos_q == PosW'($past(pos_q) + 1'b1)))
    else $error("key position did not step or wrap");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !text_op && !restart_i |=> $stable(pos_q))
    else $error("key position moved on a non-text item");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q && !out_ready_i |=> s_v_q && $stable(key_q))
    else $error("stalled front stage lost its beat");

endmodule
`default_nettype wire

### hdl/vlc_be.sv
// Back part: modular add or subtract of the key offset and bad-letter flag.
// Depends on vlc_pkg.
`default_nettype none
module vlc_be (
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire vlc_pkg::item_t in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output vlc_pkg::res_t       out_res_o
);
  import vlc_pkg::*;

  logic [LETTER_W-1:0] base;
  logic [OFF_W:0]      size, sum, diff, kw;
  logic [OFF_W-1:0]    p, k, r;
  logic                text_op;

  assign in_ready_o  = out_ready_i;
  assign out_valid_o = in_valid_i;

  assign base    = in_item_i.lang ? RUS_BASE : LAT_BASE;
  assign size    = in_item_i.lang ? RUS_SIZE : LAT_SIZE;
  assign p       = OFF_W'(in_item_i.letter - base);
  assign kw      = {1'b0, in_item_i.key};
  assign k       = (kw >= size) ? OFF_W'(kw - size) : in_item_i.key;
  assign sum     = {1'b0, p} + {1'b0, k};
  assign diff    = {1'b0, p} - {1'b0, k};
  assign text_op = (in_item_i.op == OP_ENC) || (in_item_i.op == OP_DEC);

  always_comb begin
    if (in_item_i.op == OP_DEC) begin
      r = (p < k) ? OFF_W'(diff + size) : OFF_W'(diff);
    end else begin
      r = (sum >= size) ? OFF_W'(sum - size) : OFF_W'(sum);
    end
  end

  always_comb begin
    out_res_o.letter_out = in_item_i.letter;
    out_res_o.bad_letter = 1'b0;
    case (in_item_i.op)
      OP_LOAD: out_res_o.bad_letter = !in_item_i.in_alpha;
      OP_ENC, OP_DEC: begin
        out_res_o.bad_letter = !in_item_i.in_alpha;
        if (text_op && in_item_i.in_alpha) begin
          out_res_o.letter_out = base + LETTER_W'(r);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/vigenere_letter_cipher.sv
// Vigenere letter cipher over Latin A..Z or Russian 1040..1071, top level.
// Uses:
//   push/full  : input queue side, a beat is taken when push is high and full low.
//   empty/pop  : result queue side, the oldest result shows while empty is low and
//                leaves when pop is high.
//   cfg_we_i   : writes register cfg_idx_i (0 language, 1 key length) from cfg_data_i;
//                write only while the block holds no item in flight.
// Mode 0 loads a key letter into slot key_index_i, 1 encrypts, 2 decrypts; restart_i
// returns the key position to 0 before the item. Every input beat gives one result.
// A result passes the front stage register, the middle queue and the result queue
// before it shows. Throughput: one beat per cycle while full is low.
// When pop is held low the two-entry result queue, the two-entry middle queue and
// the front stage register fill (five beats), then full rises; no beat is lost.
// Reset clears the queues, the key position and the registers (Latin, key length 1);
// the key store is not cleared and must be loaded before use.
// Depends on vlc_pkg, vlc_fifo, vlc_fe, vlc_be.
`default_nettype none
module vigenere_letter_cipher #(
  parameter int unsigned KEY_MAX = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [vlc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [vlc_pkg::KLEN_W-1:0]    cfg_data_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [vlc_pkg::LETTER_W-1:0]  letter_i,
  input  wire logic [vlc_pkg::KIDX_W-1:0]    key_index_i,
  input  wire logic                          restart_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [vlc_pkg::LETTER_W-1:0]       letter_out_o,
  output logic                               bad_letter_o
);
  import vlc_pkg::*;

  logic  fe_ready, fe_valid, mid_full, mid_empty;
  logic  be_ready, be_valid, out_full;
  item_t fe_item, mid_item;
  res_t  be_res, out_res;

  assign full = !fe_ready;

  vlc_fe #(
    .KEY_MAX(KEY_MAX)
  ) u_fe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (push),
    .in_ready_o (fe_ready),
    .mode_i     (mode_i),
    .letter_i   (letter_i),
    .key_index_i(key_index_i),
    .restart_i  (restart_i),
    .out_valid_o(fe_valid),
    .out_ready_i(!mid_full),
    .out_item_o (fe_item)
  );

  vlc_fifo #(
    .T    (item_t),
    .Depth(2)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fe_valid),
    .full_o (mid_full),
    .data_i (fe_item),
    .pop_i  (be_ready),
    .empty_o(mid_empty),
    .data_o (mid_item)
  );

  vlc_be u_be (
    .in_valid_i (!mid_empty),
    .in_ready_o (be_ready),
    .in_item_i  (mid_item),
    .out_valid_o(be_valid),
    .out_ready_i(!out_full),
    .out_res_o  (be_res)
  );

  vlc_fifo #(
    .T    (res_t),
    .Depth(2)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (be_valid),
    .full_o (out_full),
    .data_i (be_res),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (out_res)
  );

  assign letter_out_o = out_res.letter_out;
  assign bad_letter_o = out_res.bad_letter;

endmodule
`default_nettype wire

### dv/tb_vigenere_letter_cipher.sv
`timescale 1ns / 1ps
// Testbench for vigenere_letter_cipher: a directed table, then random letter traffic.
// Results are checked against the table or a bench model under random stalls on both sides.
// Depends on vlc_pkg and the cipher RTL.
module tb_vigenere_letter_cipher;
  import vlc_pkg::*;

  localparam int unsigned KEY_SLOTS   = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 160;
  localparam int unsigned PHASES      = 13;
  localparam int unsigned PHASE_BEATS = 66;
  localparam int unsigned DIR_ROWS    = 24;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [KLEN_W-1:0]    reg_val;
    op_e                  op;
    logic [LETTER_W-1:0]  letter;
    logic [KIDX_W-1:0]    kidx;
    logic                 restart;
    logic                 fixed;
    res_t                 want;
  } row_t;

  localparam row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_LOAD, 16'd68,    6'd0,  1'b0, 1'b1, '{16'd68, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd65,    6'd0,  1'b0, 1'b1, '{16'd68, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd90,    6'd0,  1'b0, 1'b1, '{16'd67, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_DEC,  16'd65,    6'd0,  1'b0, 1'b1, '{16'd88, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_DEC,  16'd90,    6'd0,  1'b0, 1'b1, '{16'd87, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd64,    6'd0,  1'b0, 1'b1, '{16'd64, 1'b1}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_DEC,  16'd91,    6'd0,  1'b0, 1'b1, '{16'd91, 1'b1}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd0,     6'd0,  1'b0, 1'b1, '{16'd0, 1'b1}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'hFFFF,  6'd0,  1'b0, 1'b1, '{16'hFFFF, 1'b1}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_NONE, 16'hFFFF,  6'd63, 1'b1, 1'b1, '{16'hFFFF, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_LOAD, 16'd0,     6'd1,  1'b0, 1'b1, '{16'd0, 1'b1}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_LOAD, 16'd90,    6'd63, 1'b1, 1'b1, '{16'd90, 1'b0}},
    '{ROW_CFG,  CFG_KEY_LENGTH, 7'd0,   OP_NONE, 16'd0,     6'd0,  1'b0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd77,    6'd0,  1'b1, 1'b0, '{16'd0, 1'b0}},
    '{ROW_CFG,  CFG_LANGUAGE,   7'h7F,  OP_NONE, 16'd0,     6'd0,  1'b0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_LOAD, 16'd1069,  6'd0,  1'b0, 1'b1, '{16'd1069, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd1040,  6'd0,  1'b0, 1'b1, '{16'd1069, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_DEC,  16'd1071,  6'd0,  1'b0, 1'b1, '{16'd1042, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd65,    6'd0,  1'b0, 1'b1, '{16'd65, 1'b1}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd1039,  6'd0,  1'b0, 1'b1, '{16'd1039, 1'b1}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_DEC,  16'd1072,  6'd0,  1'b0, 1'b1, '{16'd1072, 1'b1}},
    '{ROW_CFG,  CFG_LANGUAGE,   7'd0,   OP_NONE, 16'd0,     6'd0,  1'b0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_ENC,  16'd65,    6'd0,  1'b0, 1'b1, '{16'd68, 1'b0}},
    '{ROW_ITEM, CFG_LANGUAGE,   7'd0,   OP_LOAD, 16'd1040,  6'd2,  1'b0, 1'b1, '{16'd1040, 1'b1}}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [KLEN_W-1:0]    cfg_data_i;
  logic                 push;
  logic                 full;
  logic [1:0]           mode_i;
  logic [LETTER_W-1:0]  letter_i;
  logic [KIDX_W-1:0]    key_index_i;
  logic                 restart_i;
  logic                 empty;
  logic                 pop;
  logic [LETTER_W-1:0]  letter_out_o;
  logic                 bad_letter_o;

  logic [OFF_W-1:0]  key_slot [KEY_SLOTS];
  logic [KIDX_W-1:0] key_pos;
  logic              lang_cfg;
  logic [KLEN_W-1:0] klen_cfg;

  res_t        pending_letters [$];
  logic        send_idle;
  logic        recv_idle;
  logic        hold_req;
  int unsigned mism = 0;
  int unsigned beats_in;
  int unsigned beats_out = 0;
  int unsigned bad_seen;
  int unsigned cfg_writes;
  int unsigned long_holds = 0;
  int unsigned cycles = 0;
  int unsigned op_seen [4];

  vigenere_letter_cipher #(
    .KEY_MAX(KEY_SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .letter_i    (letter_i),
    .key_index_i (key_index_i),
    .restart_i   (restart_i),
    .empty       (empty),
    .pop         (pop),
    .letter_out_o(letter_out_o),
    .bad_letter_o(bad_letter_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic res_t cipher_letter(input op_e op, input logic [LETTER_W-1:0] letter,
                                         input logic [KIDX_W-1:0] kidx, input logic rst);
    logic [LETTER_W-1:0] base;
    logic [LETTER_W-1:0] last;
    logic                in_alpha;
    int                  size;
    int                  k;
    int                  len;
    int                  p;
    res_t                r;
    base = lang_cfg ? RUS_BASE : LAT_BASE;
    last = lang_cfg ? RUS_LAST : LAT_LAST;
    size = lang_cfg ? int'(RUS_SIZE) : int'(LAT_SIZE);
    in_alpha = (letter >= base) && (letter <= last);
    r.letter_out = letter;
    r.bad_letter = 1'b0;
    if (rst) key_pos = '0;
    case (op)
      OP_LOAD: begin
        r.bad_letter = !in_alpha;
        key_slot[kidx] = in_alpha ? OFF_W'(letter - base) : '0;
      end
      OP_ENC, OP_DEC: begin
        k = int'(key_slot[key_pos]) % size;
        len = (klen_cfg == 0) ? 1 : (klen_cfg > KEY_SLOTS) ? KEY_SLOTS : int'(klen_cfg);
        if (!in_alpha) begin
          r.bad_letter = 1'b1;
        end else begin
          p = int'(letter - base);
          r.letter_out = base + LETTER_W'((op == OP_ENC) ? (p + k) % size
                                                         : (p + size - k) % size);
        end
        key_pos = (int'(key_pos) + 1 >= len) ? '0 : key_pos + 1'b1;
      end
      default: ;
    endcase
    if (r.bad_letter) bad_seen++;
    return r;
  endfunction

  task automatic send_letter(input op_e op, input logic [LETTER_W-1:0] letter,
                             input logic [KIDX_W-1:0] kidx, input logic rst,
                             input logic fixed, input res_t want);
    int   gap;
    res_t model;
    gap = 0;
    if (send_idle && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push        <= 1'b1;
    mode_i      <= op;
    letter_i    <= letter;
    key_index_i <= kidx;
    restart_i   <= rst;
    do @(posedge clk_i); while (full);
    model = cipher_letter(op, letter, kidx, rst);
    pending_letters.insert(pending_letters.size(), fixed ? want : model);
    beats_in++;
    op_seen[int'(op)]++;
  endtask

  task automatic drain_letters();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KLEN_W-1:0] val);
    drain_letters();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LANGUAGE) lang_cfg = val[0];
    else klen_cfg = val;
    cfg_writes++;
  endtask

  task automatic send_random();
    op_e                 op;
    logic [LETTER_W-1:0] base;
    logic [LETTER_W-1:0] last;
    logic [LETTER_W-1:0] letter;
    int                  pick;
    pick = $urandom_range(0, 99);
    op = (pick < 15) ? OP_LOAD : (pick < 55) ? OP_ENC : (pick < 92) ? OP_DEC : OP_NONE;
    base = lang_cfg ? RUS_BASE : LAT_BASE;
    last = lang_cfg ? RUS_LAST : LAT_LAST;
    pick = $urandom_range(0, 99);
    if (pick < 72) letter = LETTER_W'($urandom_range(base, last));
    else if (pick < 80) letter = LETTER_W'(lang_cfg ? $urandom_range(LAT_BASE, LAT_LAST)
                                                    : $urandom_range(RUS_BASE, RUS_LAST));
    else if (pick < 90) letter = $urandom_range(0, 1) ? base - 1'b1 : last + 1'b1;
    else letter = LETTER_W'($urandom);
    send_letter(op, letter, KIDX_W'($urandom_range(0, KEY_SLOTS - 1)),
                $urandom_range(0, 9) == 0, 1'b0, '0);
  endtask

  // result side: random stalls, plus one long hold on request
  initial begin
    int   hold;
    logic hold_taken;
    hold = 0;
    hold_taken = 1'b0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold = int'(LONG_HOLD);
        hold_taken = 1'b1;
        long_holds++;
      end
      if (hold == 0 && recv_idle && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 17);
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_letters.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("unexpected beat: letter_out=%0d bad_letter=%0b", letter_out_o, bad_letter_o);
      end else begin
        want = pending_letters.pop_front();
        beats_out++;
        if (letter_out_o !== want.letter_out || bad_letter_o !== want.bad_letter) begin
          mism++;
          if (mism <= 10)
            $display("beat %0d: expected letter_out=%0d bad_letter=%0b, got %0d %0b",
                     beats_out, want.letter_out, want.bad_letter, letter_out_o, bad_letter_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_letters.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [KLEN_W-1:0] lang_val;
    logic [KLEN_W-1:0] klen_val;
    int                idle_mode;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_LANGUAGE;
    cfg_data_i  = '0;
    push        = 1'b0;
    mode_i      = OP_NONE;
    letter_i    = '0;
    key_index_i = '0;
    restart_i   = 1'b0;
    hold_req    = 1'b0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    key_pos     = '0;
    lang_cfg    = 1'b0;
    klen_cfg    = 7'd1;
    beats_in    = 0;
    bad_seen    = 0;
    cfg_writes  = 0;
    op_seen     = '{default: 0};
    foreach (key_slot[i]) key_slot[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG)
        write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].reg_val);
      else
        send_letter(DIR_TAB[i].op, DIR_TAB[i].letter, DIR_TAB[i].kidx, DIR_TAB[i].restart,
                    DIR_TAB[i].fixed, DIR_TAB[i].want);
    end

    // load every slot so that no position reads an unwritten key
    for (int s = 0; s < KEY_SLOTS; s++)
      send_letter(OP_LOAD, LETTER_W'(lang_cfg ? $urandom_range(RUS_BASE, RUS_LAST)
                                              : $urandom_range(LAT_BASE, LAT_LAST)),
                  KIDX_W'(s), 1'b0, 1'b0, '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      lang_val = KLEN_W'($urandom);
      lang_val[0] = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      case (ph)
        0: klen_val = 7'd64;
        1: klen_val = 7'd127;
        2: klen_val = 7'd0;
        3: klen_val = 7'd1;
        4: klen_val = 7'd65;
        default: klen_val = ($urandom_range(0, 3) == 0) ? 7'(($urandom_range(0, 1)) ? 127 : 0)
                                                         : 7'($urandom_range(1, 64));
      endcase
      write_reg(CFG_LANGUAGE, lang_val);
      write_reg(CFG_KEY_LENGTH, klen_val);
      idle_mode = (ph == 0) ? 3 : $urandom_range(0, 3);
      send_idle = (ph != PHASES - 1) && idle_mode[0];
      recv_idle = (ph != PHASES - 1) && idle_mode[1];
      if (ph == 3) hold_req = 1'b1;
      repeat (PHASE_BEATS) send_random();
    end

    drain_letters();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d beats in, %0d out, %0d register writes, %0d long hold(s).",
             beats_in, beats_out, cfg_writes, long_holds);
    $display("Mix: %0d loads, %0d encrypts, %0d decrypts, %0d unused mode, %0d flagged.",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], bad_seen);
    if (mism == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
